// ----- hw/rtl/sbp_pkg.sv -----
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared constants and types of the SysEx seven-bit block packer.
// ----------------------------------------------------------------------------
package sbp_pkg;

  // Firmware bytes in one block.
  localparam int BlockBytes = 32;

  localparam int PosW  = 6;
  localparam int RemW  = 3;
  localparam int ByteW = 8;

  // Longest burst one item can cause: the header, the type byte and one payload byte.
  localparam int MaxBurst = 7;
  localparam int IdxW     = 3;

  localparam int HeadLen = 5;
  localparam logic [ByteW-1:0] FrameHead [HeadLen] =
    '{8'hF0, 8'h00, 8'h20, 8'h29, 8'h00};

  localparam logic [ByteW-1:0] TypeMiddle = 8'h72;
  localparam logic [ByteW-1:0] TypeFinal  = 8'h73;
  localparam logic [ByteW-1:0] FrameEnd   = 8'hF7;
  localparam logic [ByteW-1:0] PadByte    = 8'hFF;

  // Packer state carried from one word to the next.
  typedef struct packed {
    logic [PosW-1:0]  pos;   // words taken in the current block
    logic [RemW-1:0]  rem;   // pos mod 7
    logic [ByteW-1:0] prev;  // last effective byte
  } pack_state_t;

  // Output burst caused by one input word, plus the state it leaves.
  typedef struct packed {
    logic [MaxBurst-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0]                last_idx;
    pack_state_t                    nxt;
  } pack_res_t;

endpackage

// ----- hw/rtl/sbp_pack.sv -----
// ----------------------------------------------------------------------------
// sbp_pack
// Builds the output burst and the next packer state for one input word.
// ----------------------------------------------------------------------------
module sbp_pack (
  input  logic [sbp_pkg::ByteW-1:0] data_byte_i,
  input  logic                      byte_present_i,
  input  logic                      final_block_i,
  input  sbp_pkg::pack_state_t      state_i,
  output sbp_pkg::pack_res_t        res_o
);
  import sbp_pkg::*;

  logic [ByteW-1:0]   eff_byte;
  logic [ByteW-1:0]   rem_mask;
  logic [2*ByteW-2:0] joined;
  logic [6:0]         pay_hi;
  logic [3:0]         shamt;
  logic               is_tail;

  always_comb begin
    eff_byte = byte_present_i ? data_byte_i : PadByte;
    rem_mask = (ByteW'(1) << state_i.rem) - ByteW'(1);
    joined   = {7'((state_i.prev & rem_mask)), eff_byte};
    shamt    = 4'(state_i.rem) + 4'd1;
    pay_hi   = 7'(joined >> shamt);
    is_tail  = state_i.pos >= PosW'(BlockBytes);
  end

  always_comb begin
    res_o          = '0;
    res_o.nxt.prev = eff_byte;
    if (is_tail) begin
      res_o.bytes[0] = {1'b0, pay_hi};
      res_o.bytes[1] = FrameEnd;
      res_o.last_idx = IdxW'(1);
      res_o.nxt.pos  = '0;
      res_o.nxt.rem  = '0;
    end else begin
      if (state_i.pos == '0) begin
        for (int k = 0; k < HeadLen; k++) begin
          res_o.bytes[k] = FrameHead[k];
        end
        res_o.bytes[HeadLen]   = final_block_i ? TypeFinal : TypeMiddle;
        res_o.bytes[HeadLen+1] = {1'b0, pay_hi};
        res_o.last_idx         = IdxW'(HeadLen + 1);
      end else if (state_i.rem == RemW'(6)) begin
        // seventh byte of a group completes two payload bytes
        res_o.bytes[0] = {1'b0, pay_hi};
        res_o.bytes[1] = {1'b0, joined[6:0]};
        res_o.last_idx = IdxW'(1);
      end else begin
        res_o.bytes[0] = {1'b0, pay_hi};
        res_o.last_idx = '0;
      end
      res_o.nxt.pos = state_i.pos + PosW'(1);
      res_o.nxt.rem = (state_i.rem == RemW'(6)) ? '0 : state_i.rem + RemW'(1);
    end
  end

endmodule

// ----- hw/rtl/sysex_seven_bit_block_packer_core.sv -----
// ----------------------------------------------------------------------------
// sysex_seven_bit_block_packer_core
// Packs firmware bytes MSB first into seven-bit SysEx payload bytes, framing
// each block with a header and a closing F7.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      content
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: data_byte
//                                                tuser: byte_present, final_block
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: out_byte
//                                                tlast: last_of_run
//
//  Each input word is turned into its whole burst (1, 2 or 7 bytes) in the
//  cycle it is accepted and held in a burst register.
//  The output port sends one byte per cycle while m_axis_tready is high; a
//  word causes 7 bytes as a block's first word, 1 or 2 as others and 2 as
//  the tail word. A new word is accepted in the cycle the last byte of the
//  current burst is taken.
//  A stall on m_axis holds the burst and blocks s_axis once it is full.
//  Reset clears the block position, the saved byte and the burst valid.
//
module sysex_seven_bit_block_packer_core (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser,   // [0] byte_present, [1] final_block

  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);
  import sbp_pkg::*;

  // packer state
  pack_state_t state_q;

  // burst register: bytes, last index, read index, valid
  logic [MaxBurst-1:0][ByteW-1:0] burst_q;
  logic [IdxW-1:0]                last_q;
  logic [IdxW-1:0]                idx_q, idx_d;
  logic                           busy_q, busy_d;

  pack_res_t res;
  logic      in_acc;
  logic      out_acc;
  logic      burst_end;

  sbp_pack u_pack (
    .data_byte_i    (s_axis_tdata),
    .byte_present_i (s_axis_tuser[0]),
    .final_block_i  (s_axis_tuser[1]),
    .state_i        (state_q),
    .res_o          (res)
  );

  assign burst_end     = idx_q == last_q;
  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = burst_q[idx_q];
  assign m_axis_tlast  = burst_end;

  assign out_acc       = m_axis_tvalid && m_axis_tready;
  // free now, or free once the last byte of this burst is taken
  assign s_axis_tready = !busy_q || (m_axis_tready && burst_end);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    idx_d  = idx_q;
    busy_d = busy_q;
    if (in_acc) begin
      // load a fresh burst, starting from its first byte
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (out_acc) begin
      if (burst_end) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      idx_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
      if (in_acc) begin
        state_q <= res.nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      burst_q <= res.bytes;
      last_q  <= res.last_idx;
    end
  end

  // a word is taken only while no unsent burst bytes would be overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!busy_q || (out_acc && burst_end)))
    else $error("input word accepted over an unsent burst");

  // read index never runs past the burst
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= last_q)
    else $error("burst index beyond last byte");

  // position stays within the block and its mod-7 count stays consistent
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.pos <= PosW'(BlockBytes)) && (state_q.rem < RemW'(7)))
    else $error("block position out of range");

  // a tail word leaves the block position at zero
  a_tail_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && state_q.pos == PosW'(BlockBytes)) |=> (state_q.pos == '0))
    else $error("tail word did not close the block");

endmodule

// ----- verif/sysex_seven_bit_block_packer_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sysex_seven_bit_block_packer_core_tb
// Self-checking bench for the SysEx seven-bit block packer: streams firmware
// words into the slave port, predicts every framed SysEx byte, and compares
// the master port against it under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module sysex_seven_bit_block_packer_core_tb;
  import sbp_pkg::*;

  // Stop the run here no matter what; far above the slowest correct run.
  localparam int CycleLimit = 200000;
  // Cycles the receiver holds off during the backpressure test.
  localparam int HoldCycles = 150;
  // Cycles to linger after the last expected byte (longer than one burst).
  localparam int DrainCycles = 20;

  // Directed words, packed as {final_block, byte_present, data_byte}.
  localparam int DirCount = 16;
  localparam logic [9:0] DirectedWords [DirCount] = '{
    {1'b1, 1'b1, 8'h00},  // block start, final type
    {1'b0, 1'b1, 8'hFF},
    {1'b1, 1'b0, 8'h00},  // padding; final flag off the first byte
    {1'b0, 1'b1, 8'h80},
    {1'b0, 1'b1, 8'h01},
    {1'b1, 1'b1, 8'h7F},  // final flag ignored mid-block
    {1'b0, 1'b1, 8'hAA},  // position 6: two payload bytes
    {1'b0, 1'b1, 8'h55},
    {1'b0, 1'b0, 8'hFF},  // padding with data already all ones
    {1'b0, 1'b1, 8'h00},
    {1'b0, 1'b1, 8'hFE},
    {1'b0, 1'b0, 8'h5A},
    {1'b0, 1'b1, 8'hC3},
    {1'b0, 1'b1, 8'h3C},  // position 13: two payload bytes
    {1'b0, 1'b1, 8'hFF},
    {1'b0, 1'b1, 8'h00}
  };

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } sysex_out_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic [1:0] s_axis_tuser  = 2'b00;  // [0] byte_present, [1] final_block
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  // Predictor state: mirrors the block position and last effective byte.
  logic [PosW-1:0]  blk_pos   = '0;
  logic [ByteW-1:0] prev_byte = '0;
  sysex_out_t       sysex_bytes_due [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  logic hold_start   = 1'b0;
  int   hold_left    = 0;

  sysex_seven_bit_block_packer_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes outstanding",
               cycle_count, sysex_bytes_due.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Compute the SysEx bytes one accepted word causes and queue them up.
  function automatic void pack_sysex_word(input logic [7:0] data, input logic present,
                                          input logic final_flag);
    logic [7:0]  eff;
    logic [2:0]  rem;
    logic [15:0] joined;
    logic [7:0]  burst [$];
    sysex_out_t  item;
    eff    = present ? data : PadByte;
    rem    = 3'(blk_pos % 7);
    // Prepend the bits of the previous byte that are still unsent.
    joined = {prev_byte & ((8'd1 << rem) - 8'd1), eff};
    if (blk_pos >= BlockBytes) begin
      // Tail word: top bits finish the last payload byte, then close the frame.
      burst.push_back(8'((joined >> (rem + 4'd1)) & 16'h007F));
      burst.push_back(FrameEnd);
      blk_pos = '0;
    end else begin
      if (blk_pos == '0) begin
        foreach (FrameHead[k]) burst.push_back(FrameHead[k]);
        burst.push_back(final_flag ? TypeFinal : TypeMiddle);
      end
      burst.push_back(8'((joined >> (rem + 4'd1)) & 16'h007F));
      if (rem == 3'd6) burst.push_back({1'b0, joined[6:0]});
      blk_pos = blk_pos + 1'b1;
    end
    prev_byte = eff;
    foreach (burst[k]) begin
      item.value   = burst[k];
      item.is_last = (k == burst.size() - 1);
      sysex_bytes_due.push_back(item);
    end
  endfunction

  // Offer one word after a random idle gap; predict it once it is taken.
  task automatic send_word(input logic [7:0] data, input logic present,
                           input logic final_flag);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= {final_flag, present};
    do @(posedge clk_i); while (!s_axis_tready);
    pack_sysex_word(data, present, final_flag);
  endtask

  task automatic send_random_word();
    send_word(8'($urandom_range(255)), $urandom_range(99) < 85, 1'($urandom_range(1)));
  endtask

  task automatic send_random_words(input int count);
    repeat (count) send_random_word();
  endtask

  // Receiver side: check each taken byte, then pick the next ready value.
  always @(posedge clk_i) begin : sink_side
    sysex_out_t got_exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sysex_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", m_axis_tdata,
                                  m_axis_tlast));
      end else begin
        got_exp = sysex_bytes_due.pop_front();
        if (m_axis_tdata !== got_exp.value)
          report_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata,
                                    got_exp.value));
        if (m_axis_tlast !== got_exp.is_last)
          report_mismatch($sformatf("last_of_run %0b, want %0b (byte %02h)",
                                    m_axis_tlast, got_exp.is_last, got_exp.value));
      end
    end
    // Hold ready low through a hold-off, otherwise stall at random.
    m_axis_tready <= rst_ni && (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
  end

  // Count down the receiver hold-off.
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Frame header with the final type byte, field extremes, padding and the
  // double payload byte at position 6 mod 7.
  task automatic test_block_start_fields();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    foreach (DirectedWords[k])
      send_word(DirectedWords[k][7:0], DirectedWords[k][8], DirectedWords[k][9]);
  endtask

  // Fill the block, then a padded tail with the final flag set (ignored),
  // then a new block with the middle type.
  task automatic test_tail_padding();
    while (blk_pos != BlockBytes) send_random_word();
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b0);
  endtask

  task automatic test_stream_no_idle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_random_words(22);
  endtask

  task automatic test_stream_sender_idle();
    src_idle_pct   = 62;
    sink_stall_pct = 0;
    send_random_words(22);
  endtask

  task automatic test_stream_receiver_stall();
    src_idle_pct   = 0;
    sink_stall_pct = 62;
    send_random_words(22);
  endtask

  task automatic test_stream_both_idle();
    src_idle_pct   = 21;
    sink_stall_pct = 21;
    send_random_words(22);
  endtask

  // Hold the receiver off while the sender keeps offering, so the burst
  // register fills and the input stalls.
  task automatic test_receiver_holdoff();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // drop the word already taken so it is not offered twice
    s_axis_tvalid <= 1'b0;
    hold_start    <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    send_random_words(16);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_block_start_fields();
    test_tail_padding();
    test_stream_no_idle();
    test_stream_sender_idle();
    test_stream_receiver_stall();
    test_stream_both_idle();
    test_receiver_holdoff();
    test_stream_no_idle();

    s_axis_tvalid <= 1'b0;
    sink_stall_pct = 0;
    while (sysex_bytes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
